### src/fau_pkg.sv
// Shared definitions for the formation agent update block:
// operation codes, register indexes, reset values and controller/datapath structs.
// No dependencies.
package fau_pkg;

    // fixed point fraction bits of positions and velocities
    localparam int FRAC_BITS = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP   = 2'd0;
    localparam logic [1:0] CFG_K_FORMATION = 2'd1;
    localparam logic [1:0] CFG_K_VELOCITY  = 2'd2;
    localparam logic [1:0] CFG_SPEED_CAP   = 2'd3;

    // configuration reset values
    localparam logic [15:0] RST_TIME_STEP   = 16'd1092;
    localparam logic [23:0] RST_K_FORMATION = 24'd1678;
    localparam logic [15:0] RST_K_VELOCITY  = 16'd19661;
    localparam logic [18:0] RST_SPEED_CAP   = 19'd25600;

    // shared multiplier geometry
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // multiply operations, in sequence order
    localparam logic [4:0] OP_DXX = 5'd0;   // dx^2
    localparam logic [4:0] OP_DYY = 5'd1;   // dy^2
    localparam logic [4:0] OP_DDD = 5'd2;   // D^2, forms delta
    localparam logic [4:0] OP_TX  = 5'd3;   // delta*dx into form sum x
    localparam logic [4:0] OP_TY  = 5'd4;   // delta*dy into form sum y
    localparam logic [4:0] OP_GFX = 5'd5;   // k_formation gain x
    localparam logic [4:0] OP_GVX = 5'd6;   // k_velocity gain x
    localparam logic [4:0] OP_GFY = 5'd7;
    localparam logic [4:0] OP_GVY = 5'd8;
    localparam logic [4:0] OP_PX  = 5'd9;   // ts*vx into position x
    localparam logic [4:0] OP_PY  = 5'd10;
    localparam logic [4:0] OP_VX  = 5'd11;  // ts*ax into velocity x
    localparam logic [4:0] OP_VY  = 5'd12;
    localparam logic [4:0] OP_SQX = 5'd13;  // vx^2
    localparam logic [4:0] OP_SQY = 5'd14;  // vy^2
    localparam logic [4:0] OP_MSQ = 5'd15;  // speed cap squared, speed test
    localparam logic [4:0] OP_NX  = 5'd16;  // |vx| times speed cap, divider load
    localparam logic [4:0] OP_NY  = 5'd17;

    // controller to datapath commands
    typedef struct packed {
        logic       load_item;
        logic       mul_start;
        logic [4:0] op;
        logic       store;
        logic       sqrt_step;
        logic       div_step;
        logic       div_save;
        logic       div_ysel;
        logic       out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic mul_done;
        logic last;
        logic lim;
    } t_sts;

endpackage

### src/fau_mul.sv
// Iterative shift-add multiplier, one multiplier bit per cycle.
// Depends on fau_pkg for operand widths.
module fau_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fau_pkg::MUL_A_W-1:0]   i_a,
    input  logic [fau_pkg::MUL_B_W-1:0]   i_b,
    output logic [fau_pkg::MUL_P_W-1:0]   o_p,
    output logic                          o_done
);

    localparam int CNT_W = $clog2(fau_pkg::MUL_B_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(fau_pkg::MUL_B_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [fau_pkg::MUL_A_W-1:0]   r_a;
    logic [fau_pkg::MUL_B_W-1:0]   r_b;
    logic [fau_pkg::MUL_P_W-1:0]   r_p;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // MSB-first accumulate: p = 2p + (bit ? a : 0)
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_p <= {r_p[fau_pkg::MUL_P_W-2:0], 1'b0}
                 + (r_b[fau_pkg::MUL_B_W-1] ? {{fau_pkg::MUL_B_W{1'b0}}, r_a}
                                           : {fau_pkg::MUL_P_W{1'b0}});
            r_b <= {r_b[fau_pkg::MUL_B_W-2:0], 1'b0};
        end
    end

    assign o_p    = r_p;
    assign o_done = r_done;

endmodule

### src/fau_ctrl.sv
// Sequencer for the formation agent update: steps the datapath through
// multiplies, square root and division. Depends on fau_pkg.
module fau_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  fau_pkg::t_sts i_sts,
    output fau_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MSTART = 3'd1;
    localparam logic [2:0] S_MWAIT  = 3'd2;
    localparam logic [2:0] S_SQRT   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_STEPS = 6'd20;

    logic [2:0] r_state, n_state;
    logic [4:0] r_op,    n_op;
    logic [5:0] r_cnt,   n_cnt;
    logic       r_ysel,  n_ysel;
    logic       r_ovalid, n_ovalid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_ysel  = r_ysel;
        o_cmd   = '0;
        o_cmd.op       = r_op;
        o_cmd.div_ysel = r_ysel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_op    = fau_pkg::OP_DXX;
                    n_state = S_MSTART;
                end
            end
            S_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.store = 1'b1;
                    case (r_op)
                        fau_pkg::OP_TY: begin
                            if (i_sts.last) begin
                                n_op    = fau_pkg::OP_GFX;
                                n_state = S_MSTART;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                        fau_pkg::OP_MSQ: begin
                            n_cnt   = '0;
                            n_state = i_sts.lim ? S_SQRT : S_OUT;
                        end
                        fau_pkg::OP_NX: begin
                            n_cnt   = '0;
                            n_ysel  = 1'b0;
                            n_state = S_DIV;
                        end
                        fau_pkg::OP_NY: begin
                            n_cnt   = '0;
                            n_ysel  = 1'b1;
                            n_state = S_DIV;
                        end
                        default: begin
                            n_op    = r_op + 5'd1;
                            n_state = S_MSTART;
                        end
                    endcase
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == SQRT_LAST) begin
                    n_op    = fau_pkg::OP_NX;
                    n_state = S_MSTART;
                end
            end
            S_DIV: begin
                if (r_cnt != DIV_STEPS) begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                end else begin
                    o_cmd.div_save = 1'b1;
                    if (!r_ysel) begin
                        n_op    = fau_pkg::OP_NY;
                        n_state = S_MSTART;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ovalid = o_cmd.out_load | (r_ovalid & i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= fau_pkg::OP_DXX;
            r_cnt    <= '0;
            r_ysel   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_cnt    <= n_cnt;
            r_ysel   <= n_ysel;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

`ifndef SYNTH
    // multiplier completion only lands while waiting for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.mul_done |-> (r_state == S_MWAIT))
        else $error("multiplier done outside wait state");

    // an accepted item always starts with the dx^2 multiply
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MSTART && r_op == fau_pkg::OP_DXX))
        else $error("accepted item did not start sequence");

    // square root entered only after the speed test
    a_sqrt_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> ($past(r_state) == S_SQRT ||
            ($past(r_state) == S_MWAIT && $past(r_op) == fau_pkg::OP_MSQ)))
        else $error("square root entered out of sequence");
`endif

endmodule

### src/fau_dp.sv
// Datapath of the formation agent update: item and config registers,
// accumulators, shared multiplier, square root and divider steps.
// Depends on fau_pkg and fau_mul.
module fau_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fau_pkg::t_cmd       i_cmd,
    output fau_pkg::t_sts       o_sts,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    input  logic signed [23:0]  i_self_x,
    input  logic signed [23:0]  i_self_y,
    input  logic signed [19:0]  i_self_vx,
    input  logic signed [19:0]  i_self_vy,
    input  logic signed [23:0]  i_nbr_x,
    input  logic signed [23:0]  i_nbr_y,
    input  logic signed [19:0]  i_nbr_vx,
    input  logic signed [19:0]  i_nbr_vy,
    input  logic [21:0]         i_desired_distance,
    input  logic                i_last,
    output logic signed [23:0]  o_new_x,
    output logic signed [23:0]  o_new_y,
    output logic signed [19:0]  o_new_vx,
    output logic signed [19:0]  o_new_vy,
    output logic                o_speed_limited
);

    localparam logic signed [38:0] DELTA_LIM = 39'sd274877906943;
    localparam logic signed [31:0] VEL_LIM   = 32'sd1073741824;
    localparam logic [79:0]        PROD_LIM  = 80'h2000_0000_0000_0000;

    // magnitude of a sign-extended value
    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

    // saturate 25-bit signed to 24 bits
    function automatic logic [23:0] sat24(input logic [24:0] v);
        sat24 = (v[24] ^ v[23]) ? (v[24] ? 24'h800000 : 24'h7FFFFF) : v[23:0];
    endfunction

    // saturate to the 20-bit velocity field
    function automatic logic [19:0] sat20(input logic signed [31:0] v);
        if (v > 32'sd524287)
            sat20 = 20'h7FFFF;
        else if (v < -32'sd524288)
            sat20 = 20'h80000;
        else
            sat20 = v[19:0];
    endfunction

    // gain product: floor of signed quotient, magnitude clamped
    function automatic logic [63:0] gain(input logic [79:0] q, input logic rem,
                                         input logic neg);
        logic [79:0] qc;
        logic [63:0] m;
        qc = (q > PROD_LIM) ? PROD_LIM : q;
        m  = qc[63:0] + {63'd0, rem & neg};
        gain = neg ? (64'd0 - m) : m;
    endfunction

    // configuration
    logic [15:0] r_ts;
    logic [23:0] r_kf;
    logic [15:0] r_kv;
    logic [18:0] r_ms;

    // item
    logic signed [23:0] r_sx, r_sy, r_nx, r_ny;
    logic signed [19:0] r_svx, r_svy, r_nvx, r_nvy;
    logic [21:0]        r_dd;
    logic               r_last;

    // accumulators
    logic signed [63:0] r_fsx, r_fsy;
    logic signed [23:0] r_vsx, r_vsy;

    // working values
    logic [49:0]        r_sq;
    logic signed [38:0] r_delta;
    logic signed [63:0] r_ax, r_ay;
    logic signed [23:0] r_px, r_py;
    logic signed [31:0] r_vx, r_vy;
    logic [61:0]        r_s2;
    logic               r_lim;
    logic signed [19:0] r_fvx, r_fvy;
    logic [62:0]        r_sn, r_sr, r_sbit;
    logic [31:0]        r_drem;
    logic [19:0]        r_dq;

    // output payload
    logic signed [23:0] r_ox, r_oy;
    logic signed [19:0] r_ovx, r_ovy;
    logic               r_olim;

    logic [63:0] w_ma;
    logic [31:0] w_mb;
    logic [95:0] w_p;
    logic        w_mdone;

    logic signed [24:0] w_dx, w_dy;
    logic [63:0] w_adx, w_ady, w_adel, w_afsx, w_afsy, w_avsx, w_avsy;
    logic [63:0] w_asvx, w_asvy, w_aax, w_aay, w_avx, w_avy;
    logic        w_gneg;

    fau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_p     (w_p),
        .o_done  (w_mdone)
    );

    // offsets and magnitudes
    assign w_dx   = $signed({r_nx[23], r_nx}) - $signed({r_sx[23], r_sx});
    assign w_dy   = $signed({r_ny[23], r_ny}) - $signed({r_sy[23], r_sy});
    assign w_adx  = mag64(64'(w_dx));
    assign w_ady  = mag64(64'(w_dy));
    assign w_adel = mag64(64'(r_delta));
    assign w_afsx = mag64(r_fsx);
    assign w_afsy = mag64(r_fsy);
    assign w_avsx = mag64(64'(r_vsx));
    assign w_avsy = mag64(64'(r_vsy));
    assign w_asvx = mag64(64'(r_svx));
    assign w_asvy = mag64(64'(r_svy));
    assign w_aax  = mag64(r_ax);
    assign w_aay  = mag64(r_ay);
    assign w_avx  = mag64(64'(r_vx));
    assign w_avy  = mag64(64'(r_vy));

    // multiplier operand select and product sign for gains
    always_comb begin
        w_ma   = '0;
        w_mb   = '0;
        w_gneg = 1'b0;
        case (i_cmd.op)
            fau_pkg::OP_DXX: begin w_ma = w_adx; w_mb = w_adx[31:0]; end
            fau_pkg::OP_DYY: begin w_ma = w_ady; w_mb = w_ady[31:0]; end
            fau_pkg::OP_DDD: begin w_ma = {42'd0, r_dd}; w_mb = {10'd0, r_dd}; end
            fau_pkg::OP_TX:  begin w_ma = w_adel; w_mb = w_adx[31:0]; end
            fau_pkg::OP_TY:  begin w_ma = w_adel; w_mb = w_ady[31:0]; end
            fau_pkg::OP_GFX: begin w_ma = w_afsx; w_mb = {8'd0, r_kf}; w_gneg = r_fsx[63]; end
            fau_pkg::OP_GVX: begin w_ma = w_avsx; w_mb = {16'd0, r_kv}; w_gneg = r_vsx[23]; end
            fau_pkg::OP_GFY: begin w_ma = w_afsy; w_mb = {8'd0, r_kf}; w_gneg = r_fsy[63]; end
            fau_pkg::OP_GVY: begin w_ma = w_avsy; w_mb = {16'd0, r_kv}; w_gneg = r_vsy[23]; end
            fau_pkg::OP_PX:  begin w_ma = w_asvx; w_mb = {16'd0, r_ts}; end
            fau_pkg::OP_PY:  begin w_ma = w_asvy; w_mb = {16'd0, r_ts}; end
            fau_pkg::OP_VX:  begin w_ma = w_aax; w_mb = {16'd0, r_ts}; w_gneg = r_ax[63]; end
            fau_pkg::OP_VY:  begin w_ma = w_aay; w_mb = {16'd0, r_ts}; w_gneg = r_ay[63]; end
            fau_pkg::OP_SQX: begin w_ma = w_avx; w_mb = w_avx[31:0]; end
            fau_pkg::OP_SQY: begin w_ma = w_avy; w_mb = w_avy[31:0]; end
            fau_pkg::OP_MSQ: begin w_ma = {45'd0, r_ms}; w_mb = {13'd0, r_ms}; end
            fau_pkg::OP_NX:  begin w_ma = w_avx; w_mb = {13'd0, r_ms}; end
            fau_pkg::OP_NY:  begin w_ma = w_avy; w_mb = {13'd0, r_ms}; end
            default: ;
        endcase
    end

    // delta = floor((d^2 - D^2) / 2^F), clamped
    logic signed [50:0] w_diff, w_dsh;
    logic signed [38:0] w_delta;
    assign w_diff = $signed({1'b0, r_sq}) - $signed({7'd0, w_p[43:0]});
    assign w_dsh  = w_diff >>> fau_pkg::FRAC_BITS;
    assign w_delta = (w_dsh > 51'(DELTA_LIM))  ? DELTA_LIM :
                     (w_dsh < -51'(DELTA_LIM)) ? -DELTA_LIM : w_dsh[38:0];

    // formation term floor(delta*d / 2^F) and saturating sum
    logic        w_tneg;
    logic [62:0] w_tround, w_tmag;
    logic signed [64:0] w_term, w_fsum;
    logic signed [63:0] w_fsold, w_fsnew;
    assign w_tneg   = r_delta[38] ^ ((i_cmd.op == fau_pkg::OP_TY) ? w_dy[24] : w_dx[24]);
    assign w_tround = {1'b0, w_p[61:0]} + 63'((1 << fau_pkg::FRAC_BITS) - 1);
    assign w_tmag   = (w_tneg ? w_tround : {1'b0, w_p[61:0]}) >> fau_pkg::FRAC_BITS;
    assign w_term   = w_tneg ? -$signed({2'b0, w_tmag}) : $signed({2'b0, w_tmag});
    assign w_fsold  = (i_cmd.op == fau_pkg::OP_TY) ? r_fsy : r_fsx;
    assign w_fsum   = $signed({w_fsold[63], w_fsold}) + w_term;
    assign w_fsnew  = (w_fsum[64] ^ w_fsum[63])
                    ? (w_fsum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : w_fsum[63:0];

    // velocity difference sums
    logic signed [20:0] w_vdx, w_vdy;
    logic signed [24:0] w_vsxn, w_vsyn;
    assign w_vdx  = $signed({r_nvx[19], r_nvx}) - $signed({r_svx[19], r_svx});
    assign w_vdy  = $signed({r_nvy[19], r_nvy}) - $signed({r_svy[19], r_svy});
    assign w_vsxn = 25'(r_vsx) + 25'(w_vdx);
    assign w_vsyn = 25'(r_vsy) + 25'(w_vdy);

    // gain results
    logic [63:0] w_g24, w_g16;
    assign w_g24 = gain({8'd0, w_p[95:24]}, |w_p[23:0], w_gneg);
    assign w_g16 = gain(w_p[95:16], |w_p[15:0], w_gneg);

    // position: self + floor(ts*v / 2^16)
    logic        w_pneg;
    logic [36:0] w_pround, w_pshift;
    logic [20:0] w_pmag;
    logic signed [24:0] w_pdel, w_ps;
    logic signed [23:0] w_sp;
    assign w_pneg   = (i_cmd.op == fau_pkg::OP_PY) ? r_svy[19] : r_svx[19];
    assign w_pround = {1'b0, w_p[35:0]} + 37'h0FFFF;
    assign w_pshift = (w_pneg ? w_pround : {1'b0, w_p[35:0]}) >> 16;
    assign w_pmag   = w_pshift[20:0];
    assign w_pdel   = w_pneg ? -$signed({4'd0, w_pmag}) : $signed({4'd0, w_pmag});
    assign w_sp     = (i_cmd.op == fau_pkg::OP_PY) ? r_sy : r_sx;
    assign w_ps     = $signed({w_sp[23], w_sp}) + w_pdel;

    // velocity: v + floor(ts*acc / 2^16), clamped to +-2^30
    logic signed [19:0] w_sv;
    logic signed [64:0] w_vn;
    logic signed [31:0] w_vc;
    assign w_sv = (i_cmd.op == fau_pkg::OP_VY) ? r_svy : r_svx;
    assign w_vn = 65'(w_sv) + 65'($signed(w_g16));
    assign w_vc = (w_vn > 65'(VEL_LIM))  ? VEL_LIM :
                  (w_vn < -65'(VEL_LIM)) ? -VEL_LIM : w_vn[31:0];

    // speed test
    logic w_lim;
    assign w_lim = r_s2 > {24'd0, w_p[37:0]};

    // square root step
    logic [62:0] w_strial;
    assign w_strial = r_sr + r_sbit;

    // restoring division step, divisor is the root
    logic [32:0] w_dt, w_ddiv;
    logic        w_dge;
    logic [32:0] w_dsub;
    assign w_ddiv = {1'b0, r_sr[31:0]};
    assign w_dt   = {r_drem, r_dq[19]};
    assign w_dge  = w_dt >= w_ddiv;
    assign w_dsub = w_dt - w_ddiv;

    // signed quotient
    logic               w_qneg;
    logic signed [31:0] w_q;
    assign w_qneg = i_cmd.div_ysel ? r_vy[31] : r_vx[31];
    assign w_q    = w_qneg ? -$signed({12'd0, r_dq}) : $signed({12'd0, r_dq});

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= fau_pkg::RST_TIME_STEP;
            r_kf <= fau_pkg::RST_K_FORMATION;
            r_kv <= fau_pkg::RST_K_VELOCITY;
            r_ms <= fau_pkg::RST_SPEED_CAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fau_pkg::CFG_TIME_STEP:   r_ts <= i_cfg_data[15:0];
                fau_pkg::CFG_K_FORMATION: r_kf <= i_cfg_data[23:0];
                fau_pkg::CFG_K_VELOCITY:  r_kv <= i_cfg_data[15:0];
                fau_pkg::CFG_SPEED_CAP:   r_ms <= i_cfg_data[18:0];
            endcase
        end
    end

    // accumulators, cleared after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsx <= '0;
            r_fsy <= '0;
            r_vsx <= '0;
            r_vsy <= '0;
        end else if (i_cmd.out_load) begin
            r_fsx <= '0;
            r_fsy <= '0;
            r_vsx <= '0;
            r_vsy <= '0;
        end else if (i_cmd.store && i_cmd.op == fau_pkg::OP_TX) begin
            r_fsx <= w_fsnew;
        end else if (i_cmd.store && i_cmd.op == fau_pkg::OP_TY) begin
            r_fsy <= w_fsnew;
            r_vsx <= sat24(w_vsxn);
            r_vsy <= sat24(w_vsyn);
        end
    end

    // item capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_sx   <= i_self_x;
            r_sy   <= i_self_y;
            r_svx  <= i_self_vx;
            r_svy  <= i_self_vy;
            r_nx   <= i_nbr_x;
            r_ny   <= i_nbr_y;
            r_nvx  <= i_nbr_vx;
            r_nvy  <= i_nbr_vy;
            r_dd   <= i_desired_distance;
            r_last <= i_last;
        end
        if (i_cmd.store) begin
            case (i_cmd.op)
                fau_pkg::OP_DXX: r_sq <= w_p[49:0];
                fau_pkg::OP_DYY: r_sq <= r_sq + w_p[49:0];
                fau_pkg::OP_DDD: r_delta <= w_delta;
                fau_pkg::OP_GFX: r_ax <= $signed(w_g24);
                fau_pkg::OP_GVX: r_ax <= r_ax + $signed(w_g16);
                fau_pkg::OP_GFY: r_ay <= $signed(w_g24);
                fau_pkg::OP_GVY: r_ay <= r_ay + $signed(w_g16);
                fau_pkg::OP_PX:  r_px <= sat24(w_ps);
                fau_pkg::OP_PY:  r_py <= sat24(w_ps);
                fau_pkg::OP_VX:  r_vx <= w_vc;
                fau_pkg::OP_VY:  r_vy <= w_vc;
                fau_pkg::OP_SQX: r_s2 <= w_p[61:0];
                fau_pkg::OP_SQY: r_s2 <= r_s2 + w_p[61:0];
                fau_pkg::OP_MSQ: begin
                    r_lim  <= w_lim;
                    r_fvx  <= sat20(r_vx);
                    r_fvy  <= sat20(r_vy);
                    r_sn   <= {1'b0, r_s2};
                    r_sr   <= '0;
                    r_sbit <= {1'b1, 62'd0};
                end
                fau_pkg::OP_NX, fau_pkg::OP_NY: begin
                    r_drem <= {3'd0, w_p[48:20]};
                    r_dq   <= w_p[19:0];
                end
                default: ;
            endcase
        end
        if (i_cmd.sqrt_step) begin
            if (r_sn >= w_strial) begin
                r_sn <= r_sn - w_strial;
                r_sr <= (r_sr >> 1) + r_sbit;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
        if (i_cmd.div_step) begin
            r_drem <= w_dge ? w_dsub[31:0] : w_dt[31:0];
            r_dq   <= {r_dq[18:0], w_dge};
        end
        if (i_cmd.div_save) begin
            if (i_cmd.div_ysel)
                r_fvy <= sat20(w_q);
            else
                r_fvx <= sat20(w_q);
        end
        if (i_cmd.out_load) begin
            r_ox   <= r_px;
            r_oy   <= r_py;
            r_ovx  <= r_fvx;
            r_ovy  <= r_fvy;
            r_olim <= r_lim;
        end
    end

    assign o_sts.mul_done = w_mdone;
    assign o_sts.last     = r_last;
    assign o_sts.lim      = w_lim;

    assign o_new_x         = r_ox;
    assign o_new_y         = r_oy;
    assign o_new_vx        = r_ovx;
    assign o_new_vy        = r_ovy;
    assign o_speed_limited = r_olim;

endmodule

### src/formation_agent_update.sv
// Formation agent update, one neighbor per input transfer.
// A neighbor item is accepted, then makes five passes through the shared shift-add
// multiplier. The item marked last makes sixteen passes and then an output step;
// when the speed limit engages, a 32-step root, two more passes and two divides
// come before it. One item at a time; a stalled result holds the sequencer.
// Synchronous active-low reset restores config defaults and clears the sums.
module formation_agent_update (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [23:0]  i_self_x,
    input  logic signed [23:0]  i_self_y,
    input  logic signed [19:0]  i_self_vx,
    input  logic signed [19:0]  i_self_vy,
    input  logic signed [23:0]  i_nbr_x,
    input  logic signed [23:0]  i_nbr_y,
    input  logic signed [19:0]  i_nbr_vx,
    input  logic signed [19:0]  i_nbr_vy,
    input  logic [21:0]         i_desired_distance,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [23:0]  o_new_x,
    output logic signed [23:0]  o_new_y,
    output logic signed [19:0]  o_new_vx,
    output logic signed [19:0]  o_new_vy,
    output logic                o_speed_limited,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);

    fau_pkg::t_cmd w_cmd;
    fau_pkg::t_sts w_sts;

    // sequencer
    fau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // arithmetic
    fau_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_self_x           (i_self_x),
        .i_self_y           (i_self_y),
        .i_self_vx          (i_self_vx),
        .i_self_vy          (i_self_vy),
        .i_nbr_x            (i_nbr_x),
        .i_nbr_y            (i_nbr_y),
        .i_nbr_vx           (i_nbr_vx),
        .i_nbr_vy           (i_nbr_vy),
        .i_desired_distance (i_desired_distance),
        .i_last             (i_last),
        .o_new_x            (o_new_x),
        .o_new_y            (o_new_y),
        .o_new_vx           (o_new_vx),
        .o_new_vy           (o_new_vy),
        .o_speed_limited    (o_speed_limited)
    );

endmodule

### sim/fau_checker.sv
// Checker for the formation agent update block: watches the input, output and
// configuration ports, predicts each update and compares it field by field.
// Depends on fau_pkg for register indexes and reset values.
module fau_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [23:0] i_self_x,
    input  logic signed [23:0] i_self_y,
    input  logic signed [19:0] i_self_vx,
    input  logic signed [19:0] i_self_vy,
    input  logic signed [23:0] i_nbr_x,
    input  logic signed [23:0] i_nbr_y,
    input  logic signed [19:0] i_nbr_vx,
    input  logic signed [19:0] i_nbr_vy,
    input  logic [21:0]        i_desired_distance,
    input  logic               i_last,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [23:0] i_new_x,
    input  logic signed [23:0] i_new_y,
    input  logic signed [19:0] i_new_vx,
    input  logic signed [19:0] i_new_vy,
    input  logic               i_speed_limited,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [19:0] vx;
        logic signed [19:0] vy;
        logic               lim;
    } t_update;

    localparam longint DELTA_MAX = 64'sd274877906943;
    localparam longint VEL_MAX   = 64'sd1 << 30;

    t_update updates_due[$];

    // configuration copy and neighbor sums
    longint unsigned ts, kf, kv, vmax;
    longint          fsum_x, fsum_y, vsum_x, vsum_y;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint add_clip64(longint a, longint b);
        logic signed [64:0] t;
        t = 65'(a) + 65'(b);
        if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (t < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return longint'(t);
    endfunction

    // floor(a*k / 2^sh), magnitude limited to 2^61 before the sign is applied
    function automatic longint gain(longint a, longint unsigned k, int sh);
        logic [63:0]  m;
        logic [127:0] p;
        logic [63:0]  q;
        logic         rem;
        m   = (a < 0) ? 64'(-a) : 64'(a);
        p   = {64'd0, m} * {64'd0, k};
        q   = 64'(p >> sh);
        rem = (p & ((128'd1 << sh) - 1)) != 0;
        if (q > (64'd1 << 61)) q = 64'd1 << 61;
        if (a < 0) return -longint'(q + 64'(rem));
        return longint'(q);
    endfunction

    function automatic longint unsigned root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // fold one neighbor into the sums; on the last one, queue the update
    task automatic take_neighbor();
        longint sx, sy, svx, svy, dx, dy, dd, delta, ax, ay, px, py, vx, vy, s;
        longint unsigned s2;
        t_update u;
        sx  = i_self_x;   sy  = i_self_y;
        svx = i_self_vx;  svy = i_self_vy;
        dx  = longint'(i_nbr_x) - sx;
        dy  = longint'(i_nbr_y) - sy;
        dd  = longint'({1'b0, i_desired_distance});
        delta = clip((dx * dx + dy * dy - dd * dd) >>> fau_pkg::FRAC_BITS,
                     -DELTA_MAX, DELTA_MAX);
        fsum_x = add_clip64(fsum_x, (delta * dx) >>> fau_pkg::FRAC_BITS);
        fsum_y = add_clip64(fsum_y, (delta * dy) >>> fau_pkg::FRAC_BITS);
        vsum_x = clip(vsum_x + longint'(i_nbr_vx) - svx, -8388608, 8388607);
        vsum_y = clip(vsum_y + longint'(i_nbr_vy) - svy, -8388608, 8388607);
        if (i_last) begin
            ax = gain(fsum_x, kf, 24) + gain(vsum_x, kv, 16);
            ay = gain(fsum_y, kf, 24) + gain(vsum_y, kv, 16);
            px = clip(sx + ((longint'(ts) * svx) >>> 16), -8388608, 8388607);
            py = clip(sy + ((longint'(ts) * svy) >>> 16), -8388608, 8388607);
            vx = clip(svx + gain(ax, ts, 16), -VEL_MAX, VEL_MAX);
            vy = clip(svy + gain(ay, ts, 16), -VEL_MAX, VEL_MAX);
            s2 = longint'(vx * vx) + longint'(vy * vy);
            u.lim = s2 > vmax * vmax;
            if (u.lim) begin
                s  = longint'(root(s2));
                vx = vx * longint'(vmax) / s;
                vy = vy * longint'(vmax) / s;
            end
            u.x  = 24'(px);
            u.y  = 24'(py);
            u.vx = 20'(clip(vx, -524288, 524287));
            u.vy = 20'(clip(vy, -524288, 524287));
            updates_due = {updates_due, u};
            fsum_x = 0; fsum_y = 0; vsum_x = 0; vsum_y = 0;
        end
    endtask

    // compare one update transfer with the oldest prediction
    task automatic check_update();
        t_update u;
        if (updates_due.size() == 0) begin
            $error("unexpected update transfer");
            o_errors++;
            return;
        end
        u = updates_due.pop_front();
        if (i_new_x !== u.x) begin
            $error("new_x: expected %0d, got %0d", u.x, i_new_x);
            o_errors++;
        end
        if (i_new_y !== u.y) begin
            $error("new_y: expected %0d, got %0d", u.y, i_new_y);
            o_errors++;
        end
        if (i_new_vx !== u.vx) begin
            $error("new_vx: expected %0d, got %0d", u.vx, i_new_vx);
            o_errors++;
        end
        if (i_new_vy !== u.vy) begin
            $error("new_vy: expected %0d, got %0d", u.vy, i_new_vy);
            o_errors++;
        end
        if (i_speed_limited !== u.lim) begin
            $error("speed_limited: expected %0d, got %0d", u.lim, i_speed_limited);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ts = fau_pkg::RST_TIME_STEP; kf = fau_pkg::RST_K_FORMATION;
            kv = fau_pkg::RST_K_VELOCITY; vmax = fau_pkg::RST_SPEED_CAP;
            fsum_x = 0; fsum_y = 0; vsum_x = 0; vsum_y = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fau_pkg::CFG_TIME_STEP:   ts   = i_cfg_data[15:0];
                    fau_pkg::CFG_K_FORMATION: kf   = i_cfg_data[23:0];
                    fau_pkg::CFG_K_VELOCITY:  kv   = i_cfg_data[15:0];
                    fau_pkg::CFG_SPEED_CAP:   vmax = i_cfg_data[18:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) check_update();
            if (i_in_valid && !i_in_stall) take_neighbor();
        end
        o_pending = updates_due.size();
    end
endmodule

### sim/testbench.sv
// Top of the formation agent update testbench: clock, reset, neighbor stimulus,
// configuration phases, receiver stalls and the verdict.
// Depends on fau_pkg, formation_agent_update and fau_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = 800;

    logic               clk, rst_n;
    logic               in_valid, in_stall, out_valid, out_stall;
    logic signed [23:0] self_x, self_y, nbr_x, nbr_y, new_x, new_y;
    logic signed [19:0] self_vx, self_vy, nbr_vx, nbr_vy, new_vx, new_vy;
    logic [21:0]        nbr_dist;
    logic               last, speed_limited;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;
    int                 errors, pending;
    int                 tx_idle_pct, rx_idle_pct;

    typedef struct {
        logic signed [23:0] sx, sy, nx, ny;
        logic signed [19:0] svx, svy, nvx, nvy;
        logic [21:0]        d;
        logic               last;
    } t_neighbor;

    formation_agent_update dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_self_x(self_x), .i_self_y(self_y), .i_self_vx(self_vx), .i_self_vy(self_vy),
        .i_nbr_x(nbr_x), .i_nbr_y(nbr_y), .i_nbr_vx(nbr_vx), .i_nbr_vy(nbr_vy),
        .i_desired_distance(nbr_dist), .i_last(last),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_new_x(new_x), .o_new_y(new_y), .o_new_vx(new_vx), .o_new_vy(new_vy),
        .o_speed_limited(speed_limited),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    fau_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_self_x(self_x), .i_self_y(self_y), .i_self_vx(self_vx), .i_self_vy(self_vy),
        .i_nbr_x(nbr_x), .i_nbr_y(nbr_y), .i_nbr_vx(nbr_vx), .i_nbr_vy(nbr_vy),
        .i_desired_distance(nbr_dist), .i_last(last),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_new_x(new_x), .i_new_y(new_y), .i_new_vx(new_vx), .i_new_vy(new_vy),
        .i_speed_limited(speed_limited),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stalls
    initial begin
        out_stall = 0;
        forever begin
            @(posedge clk);
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // one neighbor transfer, with optional idle cycles ahead of it
    task automatic send(t_neighbor n);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        self_x <= n.sx;  self_y <= n.sy;  self_vx <= n.svx; self_vy <= n.svy;
        nbr_x  <= n.nx;  nbr_y  <= n.ny;  nbr_vx  <= n.nvx; nbr_vy  <= n.nvy;
        nbr_dist <= n.d; last   <= n.last;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one register write; the caller drops the enable after the last one
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic set_regs(logic [15:0] t, logic [23:0] kf, logic [15:0] kv, logic [18:0] ms);
        write_reg(fau_pkg::CFG_TIME_STEP, 24'(t));
        write_reg(fau_pkg::CFG_K_FORMATION, kf);
        write_reg(fau_pkg::CFG_K_VELOCITY, 24'(kv));
        write_reg(fau_pkg::CFG_SPEED_CAP, 24'(ms));
        cfg_we <= 0;
    endtask

    // mostly scene-sized values, sometimes full range or an extreme
    function automatic logic [23:0] pos_val();
        int r;
        r = $urandom_range(99);
        if (r < 20) return 24'($urandom);
        if (r < 28) return ($urandom_range(1)) ? 24'h7FFFFF : 24'h800000;
        return 24'($signed($urandom_range(256000)) - 128000);
    endfunction

    function automatic logic [19:0] vel_val();
        int r;
        r = $urandom_range(99);
        if (r < 20) return 20'($urandom);
        if (r < 28) return ($urandom_range(1)) ? 20'h7FFFF : 20'h80000;
        return 20'($signed($urandom_range(51200)) - 25600);
    endfunction

    function automatic logic [21:0] dist_val();
        int r;
        r = $urandom_range(99);
        if (r < 20) return 22'($urandom);
        if (r < 25) return ($urandom_range(1)) ? 22'h3FFFFF : 22'd0;
        return 22'($urandom_range(51200));
    endfunction

    // random agents: a run of neighbors closed by last, plus stray breaks
    task automatic random_agents(int items);
        t_neighbor n;
        int k, cnt;
        cnt = 0;
        while (cnt < items) begin
            n.sx = pos_val(); n.sy = pos_val(); n.svx = vel_val(); n.svy = vel_val();
            k = ($urandom_range(9) == 0) ? 1 + $urandom_range(19) : 1 + $urandom_range(5);
            for (int j = 0; j < k; j++) begin
                // self fields occasionally change inside one agent
                if ($urandom_range(19) == 0) begin
                    n.sx = pos_val(); n.svy = vel_val();
                end
                n.nx = pos_val(); n.ny = pos_val();
                n.nvx = vel_val(); n.nvy = vel_val();
                n.d = dist_val();
                n.last = (j == k - 1);
                send(n);
                cnt++;
            end
        end
        n.last = 1;
        send(n);
    endtask

    function automatic t_neighbor mk(logic [23:0] sx, logic [23:0] sy, logic [19:0] sv,
                                     logic [23:0] nx, logic [19:0] nv, logic [21:0] d,
                                     logic l);
        t_neighbor n;
        n.sx = sx; n.sy = sy; n.svx = sv; n.svy = sv;
        n.nx = nx; n.ny = nx; n.nvx = nv; n.nvy = nv;
        n.d = d; n.last = l;
        return n;
    endfunction

    initial begin
        rst_n = 0; in_valid = 0; cfg_we = 0; cfg_index = fau_pkg::CFG_TIME_STEP;
        cfg_data = 0;
        self_x = 0; self_y = 0; self_vx = 0; self_vy = 0;
        nbr_x = 0; nbr_y = 0; nbr_vx = 0; nbr_vy = 0; nbr_dist = 0; last = 0;
        tx_idle_pct = 0; rx_idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: all zero, extremes, a short agent, speed limit hit
        send(mk(0, 0, 0, 0, 0, 0, 1));
        send(mk(24'h7FFFFF, 24'h7FFFFF, 20'h7FFFF, 24'h800000, 20'h80000, 22'h3FFFFF, 1));
        send(mk(24'h800000, 24'h800000, 20'h80000, 24'h7FFFFF, 20'h7FFFF, 22'h0, 1));
        send(mk(24'h7FFFFF, 24'h800000, 20'h7FFFF, 24'h7FFFFF, 20'h7FFFF, 22'h3FFFFF, 1));
        send(mk(0, 0, 20'd2560, 24'd25600, 20'd5120, 22'd12800, 0));
        send(mk(0, 0, 20'd2560, -24'sd25600, 20'd0, 22'd12800, 0));
        send(mk(0, 0, 20'd2560, 24'd2560, 20'd2560, 22'd2560, 1));
        send(mk(0, 0, 20'd51200, 24'd256, 20'd51200, 22'd256, 1));
        // velocity sums saturate after many extreme differences
        for (int i = 0; i < 12; i++)
            send(mk(0, 0, 20'h80000, 24'd1000, 20'h7FFFF, 22'd10, i == 11));
        drain();

        // random phases: three idling patterns, two register settings each
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_regs(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 19'h7FFFF);
                1: set_regs(16'h0, 24'h0, 16'h0, 19'h0);
                2: set_regs(16'($urandom), 24'($urandom), 16'($urandom), 19'($urandom_range(51200)));
                3: set_regs(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 19'h0);
                4: set_regs(fau_pkg::RST_TIME_STEP, fau_pkg::RST_K_FORMATION,
                            fau_pkg::RST_K_VELOCITY, fau_pkg::RST_SPEED_CAP);
                default: set_regs(16'($urandom), 24'($urandom_range(65535)), 16'($urandom),
                                  19'($urandom));
            endcase
            tx_idle_pct = (p < 2) ? 8 : (p < 4) ? 77 : 0;
            rx_idle_pct = (p < 2) ? 77 : (p < 4) ? 8 : 0;
            random_agents(270);
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
